>>> rtl/lrt_pkg.sv
// Shared constants, command and status types, and the sigmoid table of the trainer.
package lrt_pkg;

   localparam int MAX_FEATURES    = 16;
   localparam int MAX_SAMPLES     = 256;
   localparam int SIGMOID_ENTRIES = 256;

   localparam int FEAT_BITS  = $clog2(MAX_FEATURES);
   localparam int SAMP_BITS  = $clog2(MAX_SAMPLES);
   localparam int SIG_BITS   = $clog2(SIGMOID_ENTRIES);
   localparam int ADDR_BITS  = SAMP_BITS + FEAT_BITS;
   localparam int DIV_STEPS  = 52;

   localparam logic [1:0] CSR_STEP_SIZE     = 2'd0;
   localparam logic [1:0] CSR_EPOCH_COUNT   = 2'd1;
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd2;

   typedef logic [24:0] sig_rom_type [SIGMOID_ENTRIES];

   typedef enum logic [4:0] {
      ST_LOAD, ST_INIT, ST_EPOCH, ST_SAMPLE, ST_ZRD, ST_ZDRAIN, ST_SIG, ST_ERR,
      ST_GRD, ST_GDRAIN, ST_UMUL_LO, ST_UMUL_HI, ST_UDIV_START, ST_UDIV_WAIT,
      ST_UWRITE, ST_OUT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       clear_w;
      logic       clear_g;
      logic       clear_load;
      logic       z_init;
      logic       lab_rd;
      logic       issue;
      logic       phase_g;
      logic       sig;
      logic       err;
      logic       mul_lo;
      logic       mul_hi;
      logic       div_start;
      logic       w_write;
      logic       out_load;
      logic [4:0] j;
      logic [SAMP_BITS-1:0] i;
   } dp_cmd_type;

   typedef struct packed {
      logic [SAMP_BITS:0] ns;
      logic               out_free;
      logic               div_busy;
   } dp_stat_type;

   // Long division by shift and subtract, used only while the table is built.
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned dv);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= dv) begin
            r    = r - dv;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Entry k is sigmoid at the middle of its bin, from a series of exp(-|z|/16)
   // that is squared four times.
   function automatic sig_rom_type build_sig_table();
      sig_rom_type       t;
      longint            d;
      longint            sum;
      longint unsigned   a;
      longint unsigned   u;
      longint unsigned   term;
      longint unsigned   e;
      longint unsigned   den;
      longint unsigned   num;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         d    = 32 * longint'(k) + 16 - 16 * longint'(SIGMOID_ENTRIES);
         a    = (d < 0) ? longint'(-d) : d;
         u    = udiv64(a << 31, 2 * SIGMOID_ENTRIES) >> 4;
         term = 64'd1 << 31;
         sum  = longint'(term);
         for (int i = 1; i <= 20; i++) begin
            term = udiv64((term * u) >> 31, longint'(i));
            if ((i & 1) != 0) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
         end
         e = (sum < 0) ? 64'd0 : sum;
         for (int r = 0; r < 4; r++) e = (e * e) >> 31;
         den  = (64'd1 << 31) + e;
         num  = (d >= 0) ? (64'd1 << 31) : e;
         t[k] = 25'(udiv64((num << 24) + (den >> 1), den));
      end
      return t;
   endfunction

   localparam sig_rom_type SIG_TABLE = build_sig_table();

endpackage

>>> rtl/lrt_div.sv
// Restoring divider, one quotient bit per cycle, for the weight step.
module lrt_div
   import lrt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_STEPS-1:0] dividend,
   input  logic [SAMP_BITS:0]   divisor,
   output logic                 busy,
   output logic [DIV_STEPS-1:0] quotient
);

   logic [DIV_STEPS-1:0] dvd_ff, dvd_in;
   logic [SAMP_BITS:0]   rem_ff, rem_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [SAMP_BITS+1:0] shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DIV_STEPS-1]};
      fits    = shifted >= {1'b0, divisor};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = 6'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? (SAMP_BITS+1)'(shifted - {1'b0, divisor})
                       : shifted[SAMP_BITS:0];
         dvd_in = {dvd_ff[DIV_STEPS-2:0], fits};
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = dvd_ff;

endmodule

>>> rtl/lrt_datapath.sv
// Sample memories, load counters, multiply pipeline, weights, gradients and output register.
module lrt_datapath
   import lrt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic [4:0]         nf,
   input  logic [15:0]        step_size,
   input  logic signed [15:0] feature_value,
   input  logic               label,
   input  logic               last_of_data,
   input  logic               rsp_ready,
   output dp_stat_type        stat,
   output logic               rsp_valid,
   output logic [4:0]         rsp_coef_index,
   output logic signed [31:0] rsp_coef_value,
   output logic               rsp_samples_dropped,
   output logic               rsp_last_coef
);

   localparam logic signed [53:0] Z_EIGHT = 54'sd549755813888;
   localparam logic signed [53:0] W_MAX   = 54'sd2147483647;
   localparam logic signed [53:0] W_MIN   = -54'sd2147483648;

   logic signed [15:0] smem [1 << ADDR_BITS];
   logic               lmem [MAX_SAMPLES];

   logic [SAMP_BITS:0]   sc_ff, sc_in;
   logic [4:0]           fc_ff, fc_in;
   logic                 drop_ff, drop_in;
   logic [4:0]           fc_eff;
   logic                 room, completes;

   logic signed [31:0] w_ff [MAX_FEATURES+1];
   logic signed [47:0] g_ff [MAX_FEATURES+1];

   logic signed [15:0] rdata_ff;
   logic signed [31:0] a_ff;
   logic               v0_ff, g0_ff, v1_ff, g1_ff;
   logic [4:0]         j0_ff, j1_ff;
   logic signed [47:0] prod_ff;
   logic signed [53:0] z_ff;
   logic               label_ff;
   logic [24:0]        sig_ff;
   logic signed [25:0] err_ff, err_in;

   logic signed [47:0] gsel;
   logic [47:0]        mag;
   logic               sign_ff;
   logic [63:0]        p_ff;
   logic               div_busy;
   logic [DIV_STEPS-1:0] quo;
   logic signed [53:0] step, diff;
   logic signed [31:0] w_sat;
   logic [39:0]        z_off;

   logic               ovalid_ff;
   logic [4:0]         oidx_ff;
   logic signed [31:0] oval_ff;
   logic               odrop_ff, olast_ff;

   // Loading: one feature value is stored per accepted transaction while the sample memory has room.
   always_comb begin
      fc_eff    = (fc_ff >= 5'(MAX_FEATURES)) ? 5'(MAX_FEATURES - 1) : fc_ff;
      room      = sc_ff < (SAMP_BITS+1)'(MAX_SAMPLES);
      completes = 6'(fc_ff) + 6'd1 >= 6'(nf);
      sc_in     = sc_ff;
      fc_in     = fc_ff;
      drop_in   = drop_ff;
      if (cmd.clear_load) begin
         sc_in   = '0;
         fc_in   = '0;
         drop_in = 1'b0;
      end else if (cmd.accept) begin
         if (completes) begin
            if (room) sc_in = sc_ff + 1'b1;
            else      drop_in = 1'b1;
            fc_in = '0;
         end else begin
            fc_in = fc_eff + 5'd1;
            if (last_of_data) drop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff   <= '0;
         fc_ff   <= '0;
         drop_ff <= 1'b0;
      end else begin
         sc_ff   <= sc_in;
         fc_ff   <= fc_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && room) begin
         smem[{sc_ff[SAMP_BITS-1:0], fc_eff[FEAT_BITS-1:0]}] <= feature_value;
         if (completes) lmem[sc_ff[SAMP_BITS-1:0]] <= label;
      end
      if (cmd.issue) rdata_ff <= smem[{cmd.i, cmd.j[FEAT_BITS-1:0]}];
      if (cmd.lab_rd) label_ff <= lmem[cmd.i];
   end

   // Shared multiply pipeline: weight times feature for z, error times feature for gradients.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.issue;
         v1_ff <= v0_ff;
      end
      a_ff    <= cmd.phase_g ? 32'(err_ff) : w_ff[cmd.j];
      g0_ff   <= cmd.phase_g;
      j0_ff   <= cmd.j;
      prod_ff <= a_ff * rdata_ff;
      g1_ff   <= g0_ff;
      j1_ff   <= j0_ff;
   end

   always_comb begin
      z_off  = 40'(z_ff + Z_EIGHT);
      err_in = $signed({1'b0, sig_ff}) - (label_ff ? 26'sd16777216 : 26'sd0);
      gsel   = g_ff[cmd.j];
      mag    = gsel[47] ? 48'(-gsel) : 48'(gsel);
      step   = sign_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      diff   = 54'(w_ff[cmd.j]) - step;
      if (diff > W_MAX)      w_sat = 32'sh7fffffff;
      else if (diff < W_MIN) w_sat = 32'sh80000000;
      else                   w_sat = 32'(diff);
   end

   always_ff @(posedge clock) begin
      if (cmd.z_init) z_ff <= {{10{w_ff[nf][31]}}, w_ff[nf], 12'b0};
      else if (v1_ff && !g1_ff) z_ff <= z_ff + 54'(prod_ff);
      if (cmd.sig) begin
         if (z_ff < -Z_EIGHT)      sig_ff <= '0;
         else if (z_ff >= Z_EIGHT) sig_ff <= 25'd16777216;
         else                      sig_ff <= SIG_TABLE[z_off[39 -: SIG_BITS]];
      end
      if (cmd.err) err_ff <= err_in;
      if (cmd.mul_lo) begin
         sign_ff <= gsel[47];
         p_ff    <= 64'(40'(step_size) * 40'(mag[23:0]));
      end else if (cmd.mul_hi) begin
         p_ff <= p_ff + {40'(step_size) * 40'(mag[47:24]), 24'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= MAX_FEATURES; k++) begin
         if (cmd.clear_w) w_ff[k] <= '0;
         if (cmd.clear_g) g_ff[k] <= '0;
      end
      if (cmd.w_write) w_ff[cmd.j] <= w_sat;
      if (cmd.err) g_ff[nf] <= g_ff[nf] + 48'(err_in);
      if (v1_ff && g1_ff) g_ff[j1_ff] <= g_ff[j1_ff] + 48'(prod_ff >>> 12);
   end

   lrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (p_ff[63:12]),
      .divisor  (sc_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) ovalid_ff <= 1'b0;
      else if (cmd.out_load) ovalid_ff <= 1'b1;
      else if (rsp_ready) ovalid_ff <= 1'b0;
      if (cmd.out_load) begin
         oidx_ff  <= cmd.j;
         oval_ff  <= w_ff[cmd.j];
         odrop_ff <= drop_ff;
         olast_ff <= cmd.j == nf;
      end
   end

   assign stat.ns       = sc_ff;
   assign stat.out_free = !ovalid_ff || rsp_ready;
   assign stat.div_busy = div_busy;

   assign rsp_valid           = ovalid_ff;
   assign rsp_coef_index      = oidx_ff;
   assign rsp_coef_value      = oval_ff;
   assign rsp_samples_dropped = odrop_ff;
   assign rsp_last_coef       = olast_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(ovalid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= (SAMP_BITS+1)'(MAX_SAMPLES))
      else $error("sample count beyond capacity");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_pipe_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd.sig || cmd.mul_lo) |-> !v0_ff && !v1_ff)
      else $error("multiply pipeline not drained");

endmodule

>>> rtl/lrt_ctrl.sv
// Sequencer for loading, training epochs, weight updates and result output.
module lrt_ctrl
   import lrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last_of_data,
   input  logic [4:0]  nf,
   input  logic [15:0] epoch_count,
   input  dp_stat_type stat,
   output logic        req_ready,
   output dp_cmd_type  cmd
);

   state_type            state_ff, state_in;
   logic [4:0]           j_ff, j_in;
   logic [SAMP_BITS-1:0] i_ff, i_in;
   logic [15:0]          ep_ff, ep_in;
   logic                 dr_ff, dr_in;
   logic                 last_feat, last_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         j_ff     <= '0;
         i_ff     <= '0;
         ep_ff    <= '0;
         dr_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         i_ff     <= i_in;
         ep_ff    <= ep_in;
         dr_ff    <= dr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      ep_in       = ep_ff;
      dr_in       = dr_ff;
      cmd         = '0;
      cmd.j       = j_ff;
      cmd.i       = i_ff;
      req_ready   = 1'b0;
      last_feat   = j_ff == nf - 5'd1;
      last_sample = {1'b0, i_ff} + 1'b1 == stat.ns;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_last_of_data) state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.clear_w = 1'b1;
            j_in        = '0;
            ep_in       = '0;
            if (stat.ns == '0 || epoch_count == '0) state_in = ST_OUT;
            else                                   state_in = ST_EPOCH;
         end
         ST_EPOCH: begin
            cmd.clear_g = 1'b1;
            i_in        = '0;
            state_in    = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            cmd.z_init = 1'b1;
            cmd.lab_rd = 1'b1;
            j_in       = '0;
            state_in   = ST_ZRD;
         end
         ST_ZRD: begin
            cmd.issue = 1'b1;
            j_in      = j_ff + 5'd1;
            dr_in     = 1'b0;
            if (last_feat) state_in = ST_ZDRAIN;
         end
         ST_ZDRAIN: begin
            dr_in = 1'b1;
            if (dr_ff) state_in = ST_SIG;
         end
         ST_SIG: begin
            cmd.sig  = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            j_in     = '0;
            state_in = ST_GRD;
         end
         ST_GRD: begin
            cmd.issue   = 1'b1;
            cmd.phase_g = 1'b1;
            j_in        = j_ff + 5'd1;
            dr_in       = 1'b0;
            if (last_feat) state_in = ST_GDRAIN;
         end
         ST_GDRAIN: begin
            dr_in = 1'b1;
            if (dr_ff) begin
               j_in = '0;
               if (last_sample) begin
                  state_in = ST_UMUL_LO;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SAMPLE;
               end
            end
         end
         ST_UMUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_UMUL_HI;
         end
         ST_UMUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_UDIV_START;
         end
         ST_UDIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_UDIV_WAIT;
         end
         ST_UDIV_WAIT: begin
            if (!stat.div_busy) state_in = ST_UWRITE;
         end
         ST_UWRITE: begin
            cmd.w_write = 1'b1;
            if (j_ff == nf) begin
               j_in = '0;
               if (ep_ff + 16'd1 == epoch_count) begin
                  state_in = ST_OUT;
               end else begin
                  ep_in    = ep_ff + 16'd1;
                  state_in = ST_EPOCH;
               end
            end else begin
               j_in     = j_ff + 5'd1;
               state_in = ST_UMUL_LO;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               j_in         = j_ff + 5'd1;
               if (j_ff == nf) begin
                  cmd.clear_load = 1'b1;
                  state_in       = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   a_epoch_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EPOCH |-> ep_ff < epoch_count)
      else $error("epoch counter ran past the configured count");
   a_feat_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> j_ff < nf)
      else $error("feature read beyond features in use");
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_load |=> state_ff == ST_LOAD && j_ff == nf + 5'd1 || state_ff == ST_LOAD)
      else $error("load counters cleared outside end of run");

endmodule

>>> rtl/logistic_regression_trainer_unit.sv
// Top level of the logistic regression trainer: configuration registers and wiring.
// Usage: write the step size (index 0, Q4.12), epoch_count (index 1) and
// feature_count (index 2) on the csr_ channel while the block is idle; csr_ready is
// always high. Then stream the data set on the req_ channel, one feature value per
// transaction, sample after sample, the label on each sample's final value.
// Loading accepts one transaction per cycle into the sample memory.
// The transaction with req_last_of_data starts training (skipped if no sample was stored
// or epoch_count is 0); req_ready stays low until the last coefficient has entered the
// output register. Each epoch runs the multiply pipeline passes for every sample, then
// the weight updates, whose length is set by the one-bit-per-cycle divider.
// The run then emits nf + 1 rsp_ transactions, coefficients by index and finally
// the intercept with rsp_last_coef; one per cycle while rsp_ready is high. A stalled
// result stays in the output register and the sequencer waits for it.
// Reset restores the register defaults, clears the load counters and the drop flag
// and returns to loading; the sample memory is not cleared.
module logistic_regression_trainer_unit
   import lrt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_feature_value,
   input  logic               req_label,
   input  logic               req_last_of_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_coef_index,
   output logic signed [31:0] rsp_coef_value,
   output logic               rsp_samples_dropped,
   output logic               rsp_last_coef
);

   logic [15:0] lr_ff, epochs_ff;
   logic [4:0]  fcount_ff;
   logic [4:0]  nf;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff     <= 16'd410;
         epochs_ff <= 16'd100;
         fcount_ff <= 5'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_SIZE:     lr_ff     <= csr_data;
            CSR_EPOCH_COUNT:   epochs_ff <= csr_data;
            CSR_FEATURE_COUNT: fcount_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fcount_ff == '0)                      nf = 5'd1;
      else if (fcount_ff > 5'(MAX_FEATURES))    nf = 5'(MAX_FEATURES);
      else                                      nf = fcount_ff;
   end

   lrt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_of_data (req_last_of_data),
      .nf               (nf),
      .epoch_count      (epochs_ff),
      .stat             (stat),
      .req_ready        (req_ready),
      .cmd              (cmd)
   );

   lrt_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .nf                  (nf),
      .step_size           (lr_ff),
      .feature_value       (req_feature_value),
      .label               (req_label),
      .last_of_data        (req_last_of_data),
      .rsp_ready           (rsp_ready),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_coef_index      (rsp_coef_index),
      .rsp_coef_value      (rsp_coef_value),
      .rsp_samples_dropped (rsp_samples_dropped),
      .rsp_last_coef       (rsp_last_coef)
   );

endmodule
